### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/vqem_pkg.sv
// ----------------------------------------------------------------------------
// vqem_pkg
// Types, codes and constants of the virtual queue ECN marker.
// ----------------------------------------------------------------------------
package vqem_pkg;

    localparam int VQ_W      = 32;
    localparam int OCC_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // 1.0 packet in Q16.16
    localparam logic [VQ_W-1:0] ONE_PACKET = 32'h0001_0000;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VQ_LIMIT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VQ_DRAIN_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_FRONT    = 2'd3;

    localparam logic [VQ_W-1:0]  RST_VQ_LIMIT      = 32'd3145728;
    localparam logic [VQ_W-1:0]  RST_VQ_DRAIN_RATE = 32'd65536;
    localparam logic [OCC_W-1:0] RST_QUEUE_LIMIT   = 7'd64;
    localparam logic             RST_DROP_FRONT    = 1'b0;

    typedef enum logic [1:0] {
        OUTCOME_ACCEPTED = 2'd0,
        OUTCOME_DROPPED  = 2'd1,
        OUTCOME_DEQUEUED = 2'd2,
        OUTCOME_EMPTY    = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [VQ_W-1:0]  vq_limit;
        logic [VQ_W-1:0]  vq_drain_rate;
        logic [OCC_W-1:0] queue_limit;
        logic             drop_front;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_GROW,
        ST_READ,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic drain;
        logic grow;
        logic read;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/virtual_queue_ecn_marker_core.sv
// ----------------------------------------------------------------------------
// virtual_queue_ecn_marker_core
// Packet FIFO with a virtual queue that drives ECN marking on dequeue.
//
// Input channel (in_valid/in_stall): one transaction per enqueue or dequeue,
// stamped with a tick count. Output channel (out_valid/out_stall): exactly
// one result per input transaction, in order.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0
// vq_limit, 1 vq_drain_rate, 2 queue_limit, 3 drop_front. Write only while
// no transaction is in flight.
// Each accepted input runs through the sequencer steps in order: capture,
// 32x32 drain multiply, drain compare, virtual queue grow with store write,
// registered store read, result write. The next input is accepted only once
// the sequencer is back in idle. A held output stalls the sequencer in its
// last step; the next input can be accepted while a finished result still
// waits.
// Reset clears the queue, virtual queue, last time and mark flag and loads
// the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module virtual_queue_ecn_marker_core #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [vqem_pkg::VQ_W-1:0]         timestamp,
    input  logic [TAG_BITS-1:0]               packet_tag,
    input  logic                              ect_in,
    input  logic                              ce_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        outcome,
    output logic [TAG_BITS-1:0]               out_tag,
    output logic                              out_ect,
    output logic                              out_ce,
    output logic [vqem_pkg::OCC_W-1:0]        queue_length,
    output logic                              marking_active,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vqem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vqem_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import vqem_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    vqem_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vqem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    vqem_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .operation      (operation),
        .timestamp      (timestamp),
        .packet_tag     (packet_tag),
        .ect_in         (ect_in),
        .ce_in          (ce_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .out_tag        (out_tag),
        .out_ect        (out_ect),
        .out_ce         (out_ce),
        .queue_length   (queue_length),
        .marking_active (marking_active)
    );

endmodule

### rtl/vqem_cfg.sv
// ----------------------------------------------------------------------------
// vqem_cfg
// Configuration register file, written through the cfg transaction port.
// ----------------------------------------------------------------------------
module vqem_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [vqem_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [vqem_pkg::CFG_DAT_W-1:0]    wr_data,
    output vqem_pkg::cfg_t                    cfg
);
    import vqem_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vq_limit      <= RST_VQ_LIMIT;
            cfg_reg.vq_drain_rate <= RST_VQ_DRAIN_RATE;
            cfg_reg.queue_limit   <= RST_QUEUE_LIMIT;
            cfg_reg.drop_front    <= RST_DROP_FRONT;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_VQ_LIMIT:      cfg_reg.vq_limit      <= wr_data;
                CFG_VQ_DRAIN_RATE: cfg_reg.vq_drain_rate <= wr_data;
                CFG_QUEUE_LIMIT:   cfg_reg.queue_limit   <= wr_data[OCC_W-1:0];
                CFG_DROP_FRONT:    cfg_reg.drop_front    <= wr_data[0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/vqem_ctrl.sv
// ----------------------------------------------------------------------------
// vqem_ctrl
// Step sequencer: accept, multiply, drain, grow/write, read, finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vqem_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vqem_pkg::dp_status_t   status,
    output vqem_pkg::ctrl_cmd_t    cmd
);
    import vqem_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cmd.drain  = 1'b1;
                state_next = ST_GROW;
            end
            ST_GROW:
            begin
                cmd.grow   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall, state_reg == ST_MUL, "accepted transaction did not start multiply")
    `ASSERT_IMPLIES(a_finish_free, clk, rst_n, cmd.finish, !status.out_busy, "result overwrote a stalled transaction")

endmodule

### rtl/vqem_dp.sv
// ----------------------------------------------------------------------------
// vqem_dp
// Datapath: virtual queue arithmetic, packet store and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vqem_dp #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TAG_BITS    = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vqem_pkg::ctrl_cmd_t             cmd,
    output vqem_pkg::dp_status_t            status,
    input  vqem_pkg::cfg_t                  cfg,
    input  logic                            operation,
    input  logic [vqem_pkg::VQ_W-1:0]       timestamp,
    input  logic [TAG_BITS-1:0]             packet_tag,
    input  logic                            ect_in,
    input  logic                            ce_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      outcome,
    output logic [TAG_BITS-1:0]             out_tag,
    output logic                            out_ect,
    output logic                            out_ce,
    output logic [vqem_pkg::OCC_W-1:0]      queue_length,
    output logic                            marking_active
);
    import vqem_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int SUM_W   = ((IDX_W > OCC_W) ? IDX_W : OCC_W) + 1;
    localparam int LIM_CAP = (QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127;
    localparam int MEM_W   = TAG_BITS + 2;

    // captured transaction
    logic                op_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic                ect_reg;
    logic                ce_reg;
    logic [VQ_W-1:0]     elapsed_reg;
    logic [2*VQ_W-1:0]   product_reg;

    // persistent state
    logic [VQ_W-1:0]     last_time_reg;
    logic [VQ_W-1:0]     vlen_reg;
    logic                mark_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [OCC_W-1:0]    occ_reg;

    // packet store
    logic [MEM_W-1:0]    mem [QUEUE_DEPTH];
    logic [MEM_W-1:0]    rd_data_reg;

    // result register
    logic                out_valid_reg;
    outcome_t            outcome_reg;
    logic [TAG_BITS-1:0] out_tag_reg;
    logic                out_ect_reg;
    logic                out_ce_reg;
    logic [OCC_W-1:0]    queue_length_reg;
    logic                out_mark_reg;

    logic [2*VQ_W-1:0]   product_next;
    logic [VQ_W:0]       grown;
    logic [SUM_W-1:0]    tail_sum;
    logic [IDX_W-1:0]    tail_idx;
    logic [OCC_W-1:0]    occ_inc;
    logic [OCC_W-1:0]    lim;
    logic [IDX_W-1:0]    head_inc;
    logic [IDX_W-1:0]    head_next;
    logic [OCC_W-1:0]    occ_next;
    outcome_t            outcome_next;
    logic [TAG_BITS-1:0] tag_next;
    logic                ect_next;
    logic                ce_next;

    assign product_next = (2*VQ_W)'(cfg.vq_drain_rate) * (2*VQ_W)'(elapsed_reg);
    assign grown        = (VQ_W+1)'(vlen_reg) + (VQ_W+1)'(ONE_PACKET);

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);

    assign occ_inc  = occ_reg + OCC_W'(1);
    assign lim      = (cfg.queue_limit > OCC_W'(LIM_CAP)) ? OCC_W'(LIM_CAP)
                                                          : cfg.queue_limit;
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    always_comb
    begin
        head_next    = head_reg;
        occ_next     = occ_reg;
        outcome_next = OUTCOME_ACCEPTED;
        tag_next     = '0;
        ect_next     = 1'b0;
        ce_next      = 1'b0;
        if (op_reg == OP_ENQUEUE)
        begin
            if (occ_inc >= lim)
            begin
                outcome_next = OUTCOME_DROPPED;
                if (cfg.drop_front)
                begin
                    tag_next  = rd_data_reg[MEM_W-1:2];
                    ect_next  = rd_data_reg[1];
                    ce_next   = rd_data_reg[0];
                    head_next = head_inc;
                end
                else
                begin
                    tag_next = tag_reg;
                    ect_next = ect_reg;
                    ce_next  = ce_reg;
                end
            end
            else
            begin
                occ_next = occ_inc;
            end
        end
        else if (occ_reg != '0)
        begin
            outcome_next = OUTCOME_DEQUEUED;
            tag_next     = rd_data_reg[MEM_W-1:2];
            ect_next     = rd_data_reg[1];
            ce_next      = rd_data_reg[0] | (mark_reg & rd_data_reg[1]);
            head_next    = head_inc;
            occ_next     = occ_reg - OCC_W'(1);
        end
        else
        begin
            outcome_next = OUTCOME_EMPTY;
        end
    end

    // transaction capture and multiply
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            tag_reg     <= packet_tag;
            ect_reg     <= ect_in;
            ce_reg      <= ce_in;
            elapsed_reg <= timestamp - last_time_reg;
        end
        if (cmd.mul)
        begin
            product_reg <= product_next;
        end
    end

    // virtual queue and FIFO pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            vlen_reg      <= '0;
            mark_reg      <= 1'b0;
            head_reg      <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_time_reg <= timestamp;
            end
            if (cmd.drain && (vlen_reg != '0))
            begin
                if (product_reg >= (2*VQ_W)'(vlen_reg))
                begin
                    vlen_reg <= '0;
                    mark_reg <= 1'b0;
                end
                else
                begin
                    vlen_reg <= vlen_reg - product_reg[VQ_W-1:0];
                end
            end
            if (cmd.grow && (op_reg == OP_ENQUEUE))
            begin
                if (grown > (VQ_W+1)'(cfg.vq_limit))
                begin
                    mark_reg <= 1'b1;
                end
                else
                begin
                    vlen_reg <= grown[VQ_W-1:0];
                end
            end
            if (cmd.finish)
            begin
                head_reg <= head_next;
                occ_reg  <= occ_next;
            end
        end
    end

    // packet store: write in grow step, registered read in read step
    always_ff @(posedge clk)
    begin
        if (cmd.grow && (op_reg == OP_ENQUEUE))
        begin
            mem[tail_idx] <= {tag_reg, ect_reg, ce_reg};
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            outcome_reg      <= outcome_next;
            out_tag_reg      <= tag_next;
            out_ect_reg      <= ect_next;
            out_ce_reg       <= ce_next;
            queue_length_reg <= occ_next;
            out_mark_reg     <= mark_reg;
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign outcome        = outcome_reg;
    assign out_tag        = out_tag_reg;
    assign out_ect        = out_ect_reg;
    assign out_ce         = out_ce_reg;
    assign queue_length   = queue_length_reg;
    assign marking_active = out_mark_reg;

    `ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg < QUEUE_DEPTH, "occupancy at depth")
    `ASSERT_ALWAYS(a_head_bound, clk, rst_n, head_reg < QUEUE_DEPTH, "head out of range")
    `ASSERT_IMPLIES(a_mark_clear, clk, rst_n, $fell(mark_reg), vlen_reg == '0, "mark fell early")

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the virtual queue ECN marker core. A table of
// enqueue, dequeue and register rows, mostly hand-checked, runs first. Seven
// random phases follow, each with its own register setup and biased
// operation mix; all but the last add random sender gaps and receiver
// stalls. A behavioral model of the FIFO and the virtual queue predicts
// any result the table lacks; all are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vqem_pkg::*;

    localparam int FIFO_SLOTS    = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic        op;
        logic [31:0] ts;
        logic [15:0] tag;
        logic        ect;
        logic        ce;
    } packet_op_t;

    typedef struct packed {
        outcome_t         outcome;
        logic [15:0]      tag;
        logic             ect;
        logic             ce;
        logic [OCC_W-1:0] qlen;
        logic             mark;
    } report_t;

    typedef struct packed {
        logic [15:0] tag;
        logic        ect;
        logic        ce;
    } slot_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        packet_op_t           pkt;
        logic                 typed;
        report_t              rep;
        logic [CFG_IDX_W-1:0] widx;
        logic [CFG_DAT_W-1:0] wdata;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [VQ_W-1:0]      timestamp;
    logic [15:0]          packet_tag;
    logic                 ect_in;
    logic                 ce_in;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           outcome;
    logic [15:0]          out_tag;
    logic                 out_ect;
    logic                 out_ce;
    logic [OCC_W-1:0]     queue_length;
    logic                 marking_active;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // model state
    slot_t            fifo_slot [FIFO_SLOTS];
    logic [5:0]       fifo_head;
    logic [OCC_W-1:0] fifo_count;
    logic [VQ_W-1:0]  vq_length;
    logic [VQ_W-1:0]  vq_last_time;
    logic             vq_mark;
    logic [VQ_W-1:0]  cfg_vq_limit;
    logic [VQ_W-1:0]  cfg_vq_rate;
    logic [OCC_W-1:0] cfg_queue_limit;
    logic             cfg_drop_front;

    report_t   queued_reports [$];
    stim_row_t directed_rows [$];

    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int drops_seen = 0;
    int marks_seen = 0;

    virtual_queue_ecn_marker_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .timestamp      (timestamp),
        .packet_tag     (packet_tag),
        .ect_in         (ect_in),
        .ce_in          (ce_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .outcome        (outcome),
        .out_tag        (out_tag),
        .out_ect        (out_ect),
        .out_ce         (out_ce),
        .queue_length   (queue_length),
        .marking_active (marking_active),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5ns clk = ~clk;

    function automatic report_t vq_marker_step(input packet_op_t pkt);
        logic [31:0] elapsed;
        logic [63:0] drain;
        logic [32:0] grown;
        logic [6:0]  eff_limit;
        logic [5:0]  wr_slot;
        slot_t       arrival;
        slot_t       rep;
        report_t     r;
        r = '0;
        rep = '0;
        elapsed = pkt.ts - vq_last_time;
        drain = {32'd0, cfg_vq_rate} * {32'd0, elapsed};
        if (vq_length != '0)
        begin
            if (drain >= {32'd0, vq_length})
            begin
                vq_length = '0;
                vq_mark = 1'b0;
            end
            else
                vq_length = vq_length - drain[31:0];
        end
        vq_last_time = pkt.ts;
        if (pkt.op == OP_ENQUEUE)
        begin
            grown = {1'b0, vq_length} + {1'b0, ONE_PACKET};
            if (grown > {1'b0, cfg_vq_limit})
                vq_mark = 1'b1;
            else
                vq_length = grown[31:0];
            arrival.tag = pkt.tag;
            arrival.ect = pkt.ect;
            arrival.ce = pkt.ce;
            wr_slot = fifo_head + fifo_count[5:0];
            fifo_slot[wr_slot] = arrival;
            fifo_count = fifo_count + 1'b1;
            eff_limit = (cfg_queue_limit < FIFO_SLOTS) ? cfg_queue_limit : 7'(FIFO_SLOTS);
            if (fifo_count >= eff_limit)
            begin
                r.outcome = OUTCOME_DROPPED;
                drops_seen++;
                if (cfg_drop_front)
                begin
                    rep = fifo_slot[fifo_head];
                    fifo_head = fifo_head + 1'b1;
                end
                else
                    rep = arrival;
                fifo_count = fifo_count - 1'b1;
            end
            else
                r.outcome = OUTCOME_ACCEPTED;
        end
        else if (fifo_count != '0)
        begin
            r.outcome = OUTCOME_DEQUEUED;
            rep = fifo_slot[fifo_head];
            fifo_head = fifo_head + 1'b1;
            fifo_count = fifo_count - 1'b1;
            if (vq_mark && rep.ect)
            begin
                rep.ce = 1'b1;
                marks_seen++;
            end
        end
        else
            r.outcome = OUTCOME_EMPTY;
        r.tag = rep.tag;
        r.ect = rep.ect;
        r.ce = rep.ce;
        r.qlen = fifo_count;
        r.mark = vq_mark;
        return r;
    endfunction

    function automatic void add_checked(input logic op, input logic [31:0] ts,
                                        input logic [15:0] tag, input logic ect,
                                        input logic ce, input outcome_t oc,
                                        input logic [15:0] otag, input logic oect,
                                        input logic oce, input logic [6:0] qlen,
                                        input logic mark);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.pkt.op = op;
        r.pkt.ts = ts;
        r.pkt.tag = tag;
        r.pkt.ect = ect;
        r.pkt.ce = ce;
        r.typed = 1'b1;
        r.rep.outcome = oc;
        r.rep.tag = otag;
        r.rep.ect = oect;
        r.rep.ce = oce;
        r.rep.qlen = qlen;
        r.rep.mark = mark;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item(input logic op, input logic [31:0] ts,
                                     input logic [15:0] tag, input logic ect,
                                     input logic ce);
        stim_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.pkt.op = op;
        r.pkt.ts = ts;
        r.pkt.tag = tag;
        r.pkt.ect = ect;
        r.pkt.ce = ce;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.widx = idx;
        r.wdata = data;
        directed_rows.push_back(r);
    endfunction

    // all tasks below are entered and left at a falling edge
    task automatic issue(input packet_op_t pkt, input logic typed, input report_t rep);
        report_t predicted;
        operation = pkt.op;
        timestamp = pkt.ts;
        packet_tag = pkt.tag;
        ect_in = pkt.ect;
        ce_in = pkt.ce;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = vq_marker_step(pkt);
        queued_reports.push_back(typed ? rep : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (queued_reports.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_VQ_LIMIT:      cfg_vq_limit = data;
            CFG_VQ_DRAIN_RATE: cfg_vq_rate = data;
            CFG_QUEUE_LIMIT:   cfg_queue_limit = data[OCC_W-1:0];
            CFG_DROP_FRONT:    cfg_drop_front = data[0];
            default:           ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall = 1'b0;
        else if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            out_stall = 1'b1;
            stall_left = $urandom_range(0, 7);
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (queued_reports.size() == 0)
            begin
                $error("result transaction with no prediction pending");
                fail_count++;
            end
            else
            begin
                want = queued_reports.pop_front();
                results_checked++;
                if (outcome !== want.outcome)
                begin
                    $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
                    fail_count++;
                end
                if (out_tag !== want.tag)
                begin
                    $error("out_tag: expected 0x%h, actual 0x%h", want.tag, out_tag);
                    fail_count++;
                end
                if (out_ect !== want.ect)
                begin
                    $error("out_ect: expected %0d, actual %0d", want.ect, out_ect);
                    fail_count++;
                end
                if (out_ce !== want.ce)
                begin
                    $error("out_ce: expected %0d, actual %0d", want.ce, out_ce);
                    fail_count++;
                end
                if (queue_length !== want.qlen)
                begin
                    $error("queue_length: expected %0d, actual %0d", want.qlen, queue_length);
                    fail_count++;
                end
                if (marking_active !== want.mark)
                begin
                    $error("marking_active: expected %0d, actual %0d", want.mark,
                           marking_active);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int               phase;
        int               n;
        int               enq_pct;
        logic [31:0]      lim_v;
        logic [31:0]      rate_v;
        logic [31:0]      now;
        logic [OCC_W-1:0] ql;
        logic             df;
        packet_op_t       pkt;
        stim_row_t        row;

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_ENQUEUE;
        timestamp = '0;
        packet_tag = '0;
        ect_in = 1'b0;
        ce_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_VQ_LIMIT;
        cfg_data = '0;

        fifo_head = '0;
        fifo_count = '0;
        vq_length = '0;
        vq_last_time = '0;
        vq_mark = 1'b0;
        cfg_vq_limit = RST_VQ_LIMIT;
        cfg_vq_rate = RST_VQ_DRAIN_RATE;
        cfg_queue_limit = RST_QUEUE_LIMIT;
        cfg_drop_front = RST_DROP_FRONT;
        foreach (fifo_slot[i])
            fifo_slot[i] = '0;

        // reset defaults: limit 48 packets, drain 1 packet per tick
        add_checked(OP_DEQUEUE, 32'd0, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_EMPTY, 16'h0000, 1'b0, 1'b0, 7'd0, 1'b0);
        add_checked(OP_ENQUEUE, 32'd0, 16'hFFFF, 1'b1, 1'b1,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd1, 1'b0);
        add_checked(OP_DEQUEUE, 32'd0, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_DEQUEUED, 16'hFFFF, 1'b1, 1'b1, 7'd0, 1'b0);
        // elapsed time wraps
        add_checked(OP_ENQUEUE, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd1, 1'b0);
        add_write(CFG_VQ_LIMIT, 32'h0000_0000);
        add_write(CFG_VQ_DRAIN_RATE, 32'h0000_0000);
        add_checked(OP_ENQUEUE, 32'd5, 16'h1234, 1'b1, 1'b0,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd2, 1'b1);
        add_checked(OP_DEQUEUE, 32'd6, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_DEQUEUED, 16'h0000, 1'b0, 1'b0, 7'd1, 1'b1);
        add_checked(OP_DEQUEUE, 32'd7, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_DEQUEUED, 16'h1234, 1'b1, 1'b1, 7'd0, 1'b1);
        add_write(CFG_VQ_DRAIN_RATE, 32'hFFFF_FFFF);
        add_checked(OP_DEQUEUE, 32'd8, 16'hBEEF, 1'b1, 1'b1,
                    OUTCOME_EMPTY, 16'h0000, 1'b0, 1'b0, 7'd0, 1'b0);
        add_checked(OP_ENQUEUE, 32'd8, 16'h00FF, 1'b1, 1'b0,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd1, 1'b1);
        // empty virtual queue keeps the mark
        add_checked(OP_ENQUEUE, 32'd9, 16'hFF00, 1'b0, 1'b1,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd2, 1'b1);
        add_write(CFG_QUEUE_LIMIT, 32'd0);
        add_checked(OP_ENQUEUE, 32'd10, 16'hAAAA, 1'b1, 1'b1,
                    OUTCOME_DROPPED, 16'hAAAA, 1'b1, 1'b1, 7'd2, 1'b1);
        add_write(CFG_DROP_FRONT, 32'd1);
        add_checked(OP_ENQUEUE, 32'd11, 16'h5555, 1'b1, 1'b0,
                    OUTCOME_DROPPED, 16'h00FF, 1'b1, 1'b0, 7'd2, 1'b1);
        add_write(CFG_QUEUE_LIMIT, 32'd127);
        add_write(CFG_VQ_LIMIT, 32'h0003_0000);
        add_write(CFG_VQ_DRAIN_RATE, 32'h0000_8000);
        add_checked(OP_DEQUEUE, 32'd12, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_DEQUEUED, 16'hFF00, 1'b0, 1'b1, 7'd1, 1'b1);
        add_checked(OP_DEQUEUE, 32'd13, 16'h0000, 1'b0, 1'b0,
                    OUTCOME_DEQUEUED, 16'h5555, 1'b1, 1'b1, 7'd0, 1'b1);
        add_checked(OP_ENQUEUE, 32'd14, 16'h0001, 1'b1, 1'b0,
                    OUTCOME_ACCEPTED, 16'h0000, 1'b0, 1'b0, 7'd1, 1'b1);
        add_item(OP_ENQUEUE, 32'd14, 16'h0002, 1'b0, 1'b1);
        add_item(OP_ENQUEUE, 32'd30, 16'h8001, 1'b1, 1'b0);

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        gap_pct = 25;
        stall_pct = 25;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(row.widx, row.wdata);
            end
            else
            begin
                issue(row.pkt, row.typed, row.rep);
                sender_gap();
            end
        end

        now = 32'd100;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:
                begin
                    lim_v = 32'h0004_0000;
                    rate_v = 32'h0000_4000;
                    ql = 7'd8;
                    df = 1'b0;
                    enq_pct = 65;
                end
                1:
                begin
                    lim_v = $urandom_range(0, 32'h0010_0000);
                    rate_v = $urandom_range(0, 32'h0001_0000);
                    ql = 7'($urandom_range(1, 64));
                    df = 1'b1;
                    enq_pct = 70;
                end
                2:
                begin
                    lim_v = $urandom;
                    rate_v = $urandom;
                    ql = 7'd127;
                    df = 1'b0;
                    enq_pct = 80;
                end
                3:
                begin
                    lim_v = 32'hFFFF_FFFF;
                    rate_v = 32'h0000_0000;
                    ql = 7'd64;
                    df = 1'b1;
                    enq_pct = 85;
                end
                4:
                begin
                    lim_v = 32'h0000_0000;
                    rate_v = 32'h0000_0001;
                    ql = 7'd1;
                    df = 1'($urandom_range(0, 1));
                    enq_pct = 50;
                end
                5:
                begin
                    lim_v = $urandom_range(0, 32'h0008_0000);
                    rate_v = $urandom_range(0, 32'h0000_8000);
                    ql = 7'd2;
                    df = 1'b1;
                    enq_pct = 50;
                end
                default:
                begin
                    lim_v = 32'h0008_0000;
                    rate_v = 32'h0000_8000;
                    ql = 7'd16;
                    df = 1'b0;
                    enq_pct = 60;
                end
            endcase
            write_reg(CFG_VQ_LIMIT, lim_v);
            write_reg(CFG_VQ_DRAIN_RATE, rate_v);
            write_reg(CFG_QUEUE_LIMIT, {25'd0, ql});
            write_reg(CFG_DROP_FRONT, {31'd0, df});

            // last phase runs back to back on both sides
            if (phase == RANDOM_PHASES - 1)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = $urandom_range(0, 40);
                stall_pct = $urandom_range(0, 40);
            end

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pkt.op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                case ($urandom_range(0, 19))
                    0:       now = $urandom;
                    1, 2, 3: now = now + $urandom_range(4, 300);
                    default: now = now + $urandom_range(0, 3);
                endcase
                pkt.ts = now;
                pkt.tag = 16'($urandom_range(0, 16'hFFFF));
                pkt.ect = 1'($urandom_range(0, 1));
                pkt.ce = 1'($urandom_range(0, 1));
                issue(pkt, 1'b0, '0);
                if (gap_pct != 0 && $urandom_range(0, 49) == 0)
                    wait_drained();
                else
                    sender_gap();
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);

        $display("Covered %0d packet transactions and %0d register writes over %0d setups.",
                 items_sent, reg_writes, RANDOM_PHASES + 1);
        $display("Checked %0d results, including %0d drops and %0d CE marks on dequeue.",
                 results_checked, drops_seen, marks_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
